FILE: rtl/mexp_pkg.sv
package mexp_pkg;

	localparam int DEFAULT_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_WAIT,
		ST_NEXT,
		ST_MUL_WAIT,
		ST_SQR_GO,
		ST_SQR_WAIT,
		ST_WRITE
	} mexp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_status_t;

endpackage

FILE: rtl/mexp_mulmod.sv
module mexp_mulmod
	import mexp_pkg::*;
#(
	parameter int WIDTH = DEFAULT_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] n,
	output mexp_mul_status_t status,
	output logic [WIDTH-1:0] product
);

	localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] n_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH+1:0] sum;
	logic [WIDTH+2:0] diff1;
	logic [WIDTH+2:0] diff2;
	logic [WIDTH-1:0] acc_next;

	// One bit of the multiplier per cycle: acc = (2*acc + a*bit) mod n.
	// The sum stays below 3n, so at most 2n has to come off.
	always_comb begin
		sum = ({2'b00, acc_q} << 1) + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
		diff1 = {1'b0, sum} - {3'b000, n_q};
		diff2 = {1'b0, sum} - {2'b00, n_q, 1'b0};
		if (!diff2[WIDTH+2]) begin
			acc_next = diff2[WIDTH-1:0];
		end else if (!diff1[WIDTH+2]) begin
			acc_next = diff1[WIDTH-1:0];
		end else begin
			acc_next = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			n_q   <= n;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= b_q << 1;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = acc_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// When the modulus is 0 or 1 an accepted word goes straight to the output word.
// Otherwise the multiplier first reduces the base mod n; then, from the lowest exponent
// bit up, each set bit multiplies the result by the base and each bit below the top set
// bit squares the base; then the output word is loaded. Throughput: one word at a time
// through one bit-per-cycle modular multiplier; next word taken the cycle after loading.
// Reset: arst_n clears the control state and the output valid; the modulus resets to 1.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int WIDTH = DEFAULT_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [WIDTH-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] base_value,
	input  logic [WIDTH-1:0] exponent,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] power_result
);

	mexp_state_t      state_q, state_d;
	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] res_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] power_result_q;

	logic             mod_big;
	logic             mm_start;
	logic [WIDTH-1:0] mm_a;
	logic [WIDTH-1:0] mm_b;
	logic [WIDTH-1:0] mm_product;
	mexp_mul_status_t mm_stat;

	assign mod_big = |modulus_q[WIDTH-1:1];

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.n      (modulus_q),
		.status (mm_stat),
		.product(mm_product)
	);

	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		mm_a     = base_q;
		mm_b     = base_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mod_big) begin
						// Base mod n is the product 1 * base.
						mm_start = 1'b1;
						mm_a     = WIDTH'(1);
						mm_b     = base_value;
						state_d  = ST_RED_WAIT;
					end else begin
						state_d = ST_WRITE;
					end
				end
			end
			ST_RED_WAIT: begin
				if (mm_stat.done) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (exp_q == '0) begin
					state_d = ST_WRITE;
				end else if (exp_q[0]) begin
					mm_start = 1'b1;
					mm_a     = res_q;
					state_d  = ST_MUL_WAIT;
				end else begin
					mm_start = 1'b1;
					state_d  = ST_SQR_WAIT;
				end
			end
			ST_MUL_WAIT: begin
				if (mm_stat.done) begin
					// The last square is skipped when no higher exponent bit is set.
					state_d = (exp_q[WIDTH-1:1] == '0) ? ST_WRITE : ST_SQR_GO;
				end
			end
			ST_SQR_GO: begin
				mm_start = 1'b1;
				state_d  = ST_SQR_WAIT;
			end
			ST_SQR_WAIT: begin
				if (mm_stat.done) begin
					state_d = ST_NEXT;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= WIDTH'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				modulus_q <= cfg_wdata;
			end
			if (state_q == ST_WRITE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				exp_q <= exponent;
				res_q <= mod_big ? WIDTH'(1) : '0;
			end
			ST_RED_WAIT: begin
				if (mm_stat.done) begin
					base_q <= mm_product;
				end
			end
			ST_MUL_WAIT: begin
				if (mm_stat.done) begin
					res_q <= mm_product;
				end
			end
			ST_SQR_WAIT: begin
				if (mm_stat.done) begin
					base_q <= mm_product;
					exp_q  <= exp_q >> 1;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					power_result_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign power_result = power_result_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> (state_q == ST_RED_WAIT || state_q == ST_MUL_WAIT ||
			state_q == ST_SQR_WAIT))
		else $error("multiplier finished outside a wait state");

	a_start_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_stat.busy)
		else $error("multiplier started while busy");

	a_out_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_WRITE)
		else $error("output word appeared without a write step");
`endif

endmodule
